// File: hdl/length_prefixed_deframer_defines.svh
// Assertion macros used by the port-level checker of the deframer.
`ifndef LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

// Immediate implication, checked on every clock edge outside reset.
`define LPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the clock edge after the antecedent.
`define LPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lpd_pkg.sv
// Types, codes and reset constants of the length-prefixed deframer.
`default_nettype none

package lpd_pkg;

    // Width of the payload length cap register and of a stream byte.
    localparam int MAX_LEN_W = 25;
    localparam int BYTE_W    = 8;

    // Default width of the payload byte counter.
    localparam int LENGTH_COUNT_BITS_DEF = 25;

    // The header is five bytes: four length bytes, then the kind byte.
    localparam logic [2:0] LEN_BYTES = 3'd4;

    // Result event codes.
    localparam logic [1:0] EV_PAYLOAD   = 2'd0;
    localparam logic [1:0] EV_EMPTY     = 2'd1;
    localparam logic [1:0] EV_LEN_ERR   = 2'd2;
    localparam logic [1:0] EV_KIND_ERR  = 2'd3;

    // Reported frame kinds.
    localparam logic [1:0] KIND_JSON      = 2'd0;
    localparam logic [1:0] KIND_BINARY    = 2'd1;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_LEN        = 2'd0;
    localparam logic [1:0] CFG_KIND_JSON      = 2'd1;
    localparam logic [1:0] CFG_KIND_BINARY    = 2'd2;
    localparam logic [1:0] CFG_KIND_HEARTBEAT = 2'd3;

    // Configuration reset values.
    localparam logic [MAX_LEN_W-1:0] RST_MAX_LEN        = 25'd16777216;
    localparam logic [BYTE_W-1:0]    RST_KIND_JSON      = 8'd1;
    localparam logic [BYTE_W-1:0]    RST_KIND_BINARY    = 8'd2;
    localparam logic [BYTE_W-1:0]    RST_KIND_HEARTBEAT = 8'd3;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    // Input request: one stream byte.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              chunk_end;
    } t_in_req;

    // Output request: one parse result.
    typedef struct packed {
        logic [1:0]        event_res;
        logic [1:0]        frame_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
        logic [31:0]       error_value;
    } t_out_req;

    // Current configuration, handed from the register file to the parser.
    typedef struct packed {
        logic [MAX_LEN_W-1:0] max_payload_length;
        logic [BYTE_W-1:0]    kind_code_json;
        logic [BYTE_W-1:0]    kind_code_binary;
        logic [BYTE_W-1:0]    kind_code_heartbeat;
    } t_cfg;

endpackage

`default_nettype wire

// File: hdl/length_prefixed_deframer.sv
// Top level of the length-prefixed frame parser.
//
// Input channel (i_in_valid / o_in_ready / i_in_req) carries one stream byte
// per request together with a chunk-end flag. Each frame opens with a
// five-byte header: a big-endian 32-bit payload length and a kind byte.
// Output channel (o_out_valid / i_out_ready / o_out_req) carries at most one
// result per input byte: a payload byte, an empty-frame marker or a header
// error. Length bytes and discarded bytes give no result.
// A result is shown on the cycle after its byte is taken. Throughput is one
// byte per cycle unless the receiver stalls, set by the single result register.
// When the receiver stalls, the result register holds its request and the
// input keeps flowing only while that register is empty.
// The configuration port (i_cfg_we / i_cfg_index / i_cfg_data) writes one
// register per cycle and is meant to be used while the parser is idle.
// Reset (synchronous, active low) empties the result register, restores the
// default cap and kind codes, and returns the parser to the start of a header.
`default_nettype none

module length_prefixed_deframer #(
    parameter int LENGTH_COUNT_BITS = lpd_pkg::LENGTH_COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire lpd_pkg::t_in_req              i_in_req,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output lpd_pkg::t_out_req                  o_out_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [lpd_pkg::MAX_LEN_W-1:0] i_cfg_data
);

    lpd_pkg::t_cfg     cfg;
    lpd_pkg::t_out_req res_req;
    logic              res_valid;
    logic              space;
    logic              accept;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    lpd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpd_parser #(
        .LENGTH_COUNT_BITS (LENGTH_COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_req    (i_in_req),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res_req   (res_req)
    );

    lpd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_req   (res_req),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule

`default_nettype wire

// File: hdl/lpd_cfg_regs.sv
// Configuration register file of the deframer.
`default_nettype none

module lpd_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [lpd_pkg::MAX_LEN_W-1:0] i_cfg_data,
    output lpd_pkg::t_cfg                     o_cfg
);

    lpd_pkg::t_cfg r_cfg;

    // Write the addressed register; all four are restored at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_payload_length  <= lpd_pkg::RST_MAX_LEN;
            r_cfg.kind_code_json      <= lpd_pkg::RST_KIND_JSON;
            r_cfg.kind_code_binary    <= lpd_pkg::RST_KIND_BINARY;
            r_cfg.kind_code_heartbeat <= lpd_pkg::RST_KIND_HEARTBEAT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lpd_pkg::CFG_MAX_LEN: begin
                    r_cfg.max_payload_length <= i_cfg_data;
                end
                lpd_pkg::CFG_KIND_JSON: begin
                    r_cfg.kind_code_json <= i_cfg_data[lpd_pkg::BYTE_W-1:0];
                end
                lpd_pkg::CFG_KIND_BINARY: begin
                    r_cfg.kind_code_binary <= i_cfg_data[lpd_pkg::BYTE_W-1:0];
                end
                lpd_pkg::CFG_KIND_HEARTBEAT: begin
                    r_cfg.kind_code_heartbeat <= i_cfg_data[lpd_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hdl/lpd_parser.sv
// Frame parser: header collection, payload counting and error discard.
`default_nettype none

module lpd_parser #(
    parameter int LENGTH_COUNT_BITS = lpd_pkg::LENGTH_COUNT_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire lpd_pkg::t_in_req i_in_req,
    input  wire lpd_pkg::t_cfg    i_cfg,
    output logic                  o_res_valid,
    output lpd_pkg::t_out_req     o_res_req
);

    // Largest length the byte counter can hold.
    localparam logic [31:0] COUNT_MASK = 32'((64'd1 << LENGTH_COUNT_BITS) - 64'd1);

    lpd_pkg::t_phase              r_phase,        n_phase;
    logic [2:0]                   r_header_count, n_header_count;
    logic [31:0]                  r_length_shift, n_length_shift;
    logic [1:0]                   r_current_kind, n_current_kind;
    logic [LENGTH_COUNT_BITS-1:0] r_remaining,    n_remaining;

    logic        hdr_done;
    logic [31:0] cap;
    logic        len_err;
    logic        kind_hit;
    logic [1:0]  kind_idx;
    logic        pay_last;

    // Header checks: effective cap, length compare and kind lookup.
    always_comb begin
        hdr_done = (r_header_count == lpd_pkg::LEN_BYTES);
        cap      = 32'(i_cfg.max_payload_length);
        if (cap > COUNT_MASK) begin
            cap = COUNT_MASK;
        end
        len_err  = (r_length_shift > cap);
        kind_hit = 1'b1;
        if (i_in_req.data_byte == i_cfg.kind_code_json) begin
            kind_idx = lpd_pkg::KIND_JSON;
        end else if (i_in_req.data_byte == i_cfg.kind_code_binary) begin
            kind_idx = lpd_pkg::KIND_BINARY;
        end else if (i_in_req.data_byte == i_cfg.kind_code_heartbeat) begin
            kind_idx = lpd_pkg::KIND_HEARTBEAT;
        end else begin
            kind_idx = lpd_pkg::KIND_JSON;
            kind_hit = 1'b0;
        end
        // A count of one or zero marks the final payload byte.
        pay_last = (r_remaining[LENGTH_COUNT_BITS-1:1] == '0);
    end

    // Next state.
    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_length_shift = r_length_shift;
        n_current_kind = r_current_kind;
        n_remaining    = r_remaining;
        if (i_accept) begin
            case (r_phase)
                lpd_pkg::PH_DISCARD: begin
                    if (i_in_req.chunk_end) begin
                        n_phase = lpd_pkg::PH_HEADER;
                    end
                end
                lpd_pkg::PH_PAYLOAD: begin
                    n_remaining = r_remaining - LENGTH_COUNT_BITS'(1);
                    if (pay_last) begin
                        n_phase = lpd_pkg::PH_HEADER;
                    end
                end
                lpd_pkg::PH_HEADER: begin
                    if (!hdr_done) begin
                        n_length_shift = {r_length_shift[23:0], i_in_req.data_byte};
                        n_header_count = r_header_count + 3'd1;
                    end else begin
                        n_header_count = '0;
                        n_length_shift = '0;
                        if (len_err || !kind_hit) begin
                            n_phase = i_in_req.chunk_end ? lpd_pkg::PH_HEADER
                                                         : lpd_pkg::PH_DISCARD;
                        end else begin
                            n_current_kind = kind_idx;
                            if (r_length_shift != '0) begin
                                n_remaining = r_length_shift[LENGTH_COUNT_BITS-1:0];
                                n_phase     = lpd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = lpd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // Result for the byte now being accepted.
    always_comb begin
        o_res_valid = 1'b0;
        o_res_req   = '0;
        if (i_accept) begin
            case (r_phase)
                lpd_pkg::PH_PAYLOAD: begin
                    o_res_valid            = 1'b1;
                    o_res_req.event_res    = lpd_pkg::EV_PAYLOAD;
                    o_res_req.frame_kind   = r_current_kind;
                    o_res_req.payload_byte = i_in_req.data_byte;
                    o_res_req.frame_last   = pay_last;
                end
                lpd_pkg::PH_HEADER: begin
                    if (hdr_done) begin
                        if (len_err) begin
                            o_res_valid           = 1'b1;
                            o_res_req.event_res   = lpd_pkg::EV_LEN_ERR;
                            o_res_req.error_value = r_length_shift;
                        end else if (!kind_hit) begin
                            o_res_valid           = 1'b1;
                            o_res_req.event_res   = lpd_pkg::EV_KIND_ERR;
                            o_res_req.error_value = 32'(i_in_req.data_byte);
                        end else if (r_length_shift == '0) begin
                            o_res_valid          = 1'b1;
                            o_res_req.event_res  = lpd_pkg::EV_EMPTY;
                            o_res_req.frame_kind = kind_idx;
                            o_res_req.frame_last = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= lpd_pkg::PH_HEADER;
            r_header_count <= '0;
            r_length_shift <= '0;
            r_current_kind <= '0;
            r_remaining    <= '0;
        end else begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_length_shift <= n_length_shift;
            r_current_kind <= n_current_kind;
            r_remaining    <= n_remaining;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lpd_out_stage.sv
// Result register between the parser and the output channel.
`default_nettype none

module lpd_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire lpd_pkg::t_out_req i_res_req,
    output logic                   o_space,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output lpd_pkg::t_out_req      o_out_req
);

    logic              r_valid;
    lpd_pkg::t_out_req r_req;

    // The register can take a new result when empty or when its request leaves now.
    assign o_space = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_res_valid) begin
            r_req <= i_res_req;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_req   = r_req;

endmodule

`default_nettype wire

// File: hdl/lpd_checker.sv
// Port-level checker for the deframer and its bind to the top level.
`default_nettype none

`include "length_prefixed_deframer_defines.svh"

module lpd_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              o_in_ready,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire lpd_pkg::t_out_req o_out_req
);

    logic r_prev_valid;
    logic r_prev_take;
    logic out_stall;
    logic new_res;
    logic other_res;
    logic byte_clear;
    logic last_res;
    logic frame_res;

    // Previous-cycle view of the output valid and of the input handshake.
    always_ff @(posedge i_clk) begin
        r_prev_valid <= o_out_valid;
        r_prev_take  <= i_in_valid && o_in_ready;
    end

    assign out_stall  = o_out_valid && !i_out_ready;
    assign new_res    = o_out_valid && !r_prev_valid;
    assign other_res  = o_out_valid && (o_out_req.event_res != lpd_pkg::EV_PAYLOAD);
    assign byte_clear = (o_out_req.payload_byte == '0);
    assign last_res   = o_out_valid && o_out_req.frame_last;
    assign frame_res  = (o_out_req.event_res == lpd_pkg::EV_PAYLOAD) ||
                        (o_out_req.event_res == lpd_pkg::EV_EMPTY);

    // A stalled result stays on the port.
    `LPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid, "stalled result lost")

    // A new result only ever follows an accepted byte.
    `LPD_ASSERT_NOW(a_res_cause, i_clk, i_rst_n, new_res, r_prev_take, "result without a byte")

    // Only payload results carry a byte.
    `LPD_ASSERT_NOW(a_byte_zero, i_clk, i_rst_n, other_res, byte_clear, "byte on non-payload")

    // The end-of-frame mark never rides on an error.
    `LPD_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, last_res, frame_res, "end mark on an error")

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

`default_nettype wire

// File: tb/length_prefixed_deframer_checker.sv
// Checker for the length-prefixed deframer: shadows the parser and compares each result request.
module length_prefixed_deframer_checker #(
    parameter int COUNT_BITS = lpd_pkg::LENGTH_COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  lpd_pkg::t_in_req              i_in_req,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  lpd_pkg::t_out_req             i_out_req,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [lpd_pkg::MAX_LEN_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import lpd_pkg::*;

    // Largest length that the payload counter can hold.
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    // Shadow copy of the registers.
    logic [MAX_LEN_W-1:0]  len_cap;
    logic [BYTE_W-1:0]     code_json;
    logic [BYTE_W-1:0]     code_binary;
    logic [BYTE_W-1:0]     code_heartbeat;

    // Shadow copy of the parser state.
    t_phase                parse_phase;
    logic [2:0]            hdr_count;
    logic [31:0]           len_shift;
    logic [1:0]            frame_kind;
    logic [COUNT_BITS-1:0] bytes_left;

    // Results predicted but not yet seen on the output channel.
    t_out_req              results_due[$];
    int                    mismatches = 0;
    int                    due_count = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = due_count;

    // Advance the shadow parser by one stream byte and queue any result it gives.
    task automatic parse_byte(input t_in_req req);
        t_out_req    res;
        logic [32:0] cap;
        logic [1:0]  kind;
        logic        known;
        res = '0;
        case (parse_phase)
            PH_DISCARD: begin
                if (req.chunk_end) begin
                    parse_phase = PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                res.event_res    = EV_PAYLOAD;
                res.frame_kind   = frame_kind;
                res.payload_byte = req.data_byte;
                res.frame_last   = (bytes_left <= 1);
                results_due.push_back(res);
                bytes_left = bytes_left - 1'b1;
                if (res.frame_last) begin
                    parse_phase = PH_HEADER;
                end
            end
            default: begin
                if (hdr_count < LEN_BYTES) begin
                    // Length bytes arrive most significant first.
                    len_shift = {len_shift[23:0], req.data_byte};
                    hdr_count = hdr_count + 3'd1;
                end else begin
                    // Kind byte: the length is judged before the kind.
                    hdr_count = '0;
                    cap = ({8'b0, len_cap} > COUNT_MAX) ? COUNT_MAX : {8'b0, len_cap};
                    known = 1'b1;
                    kind = KIND_JSON;
                    if (req.data_byte == code_json) begin
                        kind = KIND_JSON;
                    end else if (req.data_byte == code_binary) begin
                        kind = KIND_BINARY;
                    end else if (req.data_byte == code_heartbeat) begin
                        kind = KIND_HEARTBEAT;
                    end else begin
                        known = 1'b0;
                    end
                    if ({1'b0, len_shift} > cap) begin
                        res.event_res   = EV_LEN_ERR;
                        res.error_value = len_shift;
                        results_due.push_back(res);
                        parse_phase = req.chunk_end ? PH_HEADER : PH_DISCARD;
                    end else if (!known) begin
                        res.event_res   = EV_KIND_ERR;
                        res.error_value = {24'b0, req.data_byte};
                        results_due.push_back(res);
                        parse_phase = req.chunk_end ? PH_HEADER : PH_DISCARD;
                    end else begin
                        frame_kind = kind;
                        if (len_shift == '0) begin
                            res.event_res  = EV_EMPTY;
                            res.frame_kind = kind;
                            res.frame_last = 1'b1;
                            results_due.push_back(res);
                        end else begin
                            bytes_left  = len_shift[COUNT_BITS-1:0];
                            parse_phase = PH_PAYLOAD;
                        end
                    end
                    len_shift = '0;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Both channels and the register port are sampled at the rising edge.
    always @(posedge i_clk) begin : track_parser
        t_out_req want;
        if (!i_rst_n) begin
            len_cap        = RST_MAX_LEN;
            code_json      = RST_KIND_JSON;
            code_binary    = RST_KIND_BINARY;
            code_heartbeat = RST_KIND_HEARTBEAT;
            parse_phase    = PH_HEADER;
            hdr_count      = '0;
            len_shift      = '0;
            frame_kind     = KIND_JSON;
            bytes_left     = '0;
            results_due.delete();
        end else begin
            // A result request is matched against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: event %0d, error value 0x%0h",
                           i_out_req.event_res, i_out_req.error_value);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(i_out_req.event_res));
                    check_field("frame_kind", 32'(want.frame_kind),
                                32'(i_out_req.frame_kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(i_out_req.payload_byte));
                    check_field("frame_last", 32'(want.frame_last),
                                32'(i_out_req.frame_last));
                    check_field("error_value", want.error_value, i_out_req.error_value);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_LEN:     len_cap        = i_cfg_data;
                    CFG_KIND_JSON:   code_json      = i_cfg_data[BYTE_W-1:0];
                    CFG_KIND_BINARY: code_binary    = i_cfg_data[BYTE_W-1:0];
                    default:         code_heartbeat = i_cfg_data[BYTE_W-1:0];
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_req);
            end
        end
        due_count = results_due.size();
    end

endmodule

// File: tb/length_prefixed_deframer_test.sv
// Top of the deframer testbench: stream stimulus, register setup and the verdict.
module length_prefixed_deframer_test;
    import lpd_pkg::*;

    localparam int STREAM_BYTES = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CFG_EVERY    = 150;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_req              in_req    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_req             out_req;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = CFG_MAX_LEN;
    logic [MAX_LEN_W-1:0] cfg_data  = '0;
    int                   fail_count;
    int                   due_count;

    // Stimulus-side knowledge of the registers, used to shape frames.
    logic [MAX_LEN_W-1:0] cap_now       = RST_MAX_LEN;
    logic [BYTE_W-1:0]    json_now      = RST_KIND_JSON;
    logic [BYTE_W-1:0]    binary_now    = RST_KIND_BINARY;
    logic [BYTE_W-1:0]    heartbeat_now = RST_KIND_HEARTBEAT;

    logic                 in_gaps    = 1'b1;
    logic                 out_gaps   = 1'b1;
    int                   bytes_sent = 0;
    int                   cycles     = 0;

    length_prefixed_deframer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    length_prefixed_deframer_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_req    (out_req),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (due_count)
    );

    always #6 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver stalls at random while gaps are enabled.
    always @(negedge clk) begin
        out_ready <= !(out_gaps && $urandom_range(0, 99) < 31);
    end

    // Offer one byte request and hold it until it is taken; returns on a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic ce);
        while (in_gaps && $urandom_range(0, 99) < 31) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{data_byte: b, chunk_end: ce};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Length bytes carry a stray chunk end now and then, which the parser ignores.
    task automatic send_header(input logic [31:0] len, input logic [7:0] kind,
                               input logic kind_ce);
        for (int i = 3; i >= 0; i--) begin
            send_byte(len[8*i +: 8], $urandom_range(0, 3) == 0);
        end
        send_byte(kind, kind_ce);
    endtask

    task automatic send_payload(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    // Bytes dropped after a bad header, closed by a chunk end.
    task automatic send_discard(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_frame(input int unsigned len);
        logic [7:0] code;
        case ($urandom_range(0, 2))
            0:       code = json_now;
            1:       code = binary_now;
            default: code = heartbeat_now;
        endcase
        send_header(len, code, $urandom_range(0, 3) == 0);
        send_payload(len);
    endtask

    // A header that fails on its length, or on its kind with an acceptable length.
    task automatic send_bad_header(input logic by_length);
        logic [31:0] len;
        logic [7:0]  kind;
        logic        ce;
        if (by_length) begin
            if ($urandom_range(0, 1) == 0) begin
                len = 32'(cap_now) + 32'd1 + 32'($urandom_range(0, 3));
            end else begin
                len = {8'($urandom_range(2, 255)), 24'($urandom)};
            end
            kind = 8'($urandom_range(0, 255));
        end else begin
            len = 32'($urandom_range(0, cap_now));
            do kind = 8'($urandom_range(0, 255));
            while (kind == json_now || kind == binary_now || kind == heartbeat_now);
        end
        ce = ($urandom_range(0, 2) == 0);
        send_header(len, kind, ce);
        if (!ce) begin
            send_discard($urandom_range(0, 6));
        end
    endtask

    // Registers change only once the parser has delivered everything.
    task automatic write_config(input logic [MAX_LEN_W-1:0] cap, input logic [7:0] j,
                                input logic [7:0] b, input logic [7:0] h);
        in_valid <= 1'b0;
        while (due_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= cap;
        @(negedge clk);
        cfg_index <= CFG_KIND_JSON;
        cfg_data  <= MAX_LEN_W'(j);
        @(negedge clk);
        cfg_index <= CFG_KIND_BINARY;
        cfg_data  <= MAX_LEN_W'(b);
        @(negedge clk);
        cfg_index <= CFG_KIND_HEARTBEAT;
        cfg_data  <= MAX_LEN_W'(h);
        @(negedge clk);
        cfg_we        <= 1'b0;
        cap_now       = cap;
        json_now      = j;
        binary_now    = b;
        heartbeat_now = h;
    endtask

    initial begin
        int                   stream_start;
        int                   next_cfg_at;
        int                   done_bytes;
        int                   pick;
        int unsigned          len;
        logic [MAX_LEN_W-1:0] cap;
        logic [7:0]           j, b, h;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset registers.
        send_header(32'd0, json_now, 1'b0);
        send_header(32'd1, binary_now, 1'b0);
        send_byte(8'h00, 1'b1);
        send_header(32'd2, heartbeat_now, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        // Largest length with a chunk end on the kind byte: parsing resumes at once.
        send_header(32'hFFFF_FFFF, json_now, 1'b1);
        // Length just above the cap and an unknown kind: the length is reported.
        send_header(32'd16777217, 8'h00, 1'b0);
        send_discard(2);
        send_header(32'd0, 8'hFF, 1'b0);
        send_discard(0);

        // All kind codes shared: json wins; a cap of four passes four and rejects five.
        write_config(25'd4, 8'd7, 8'd7, 8'd7);
        send_header(32'd4, 8'd7, 1'b0);
        send_payload(4);
        send_header(32'd5, 8'd7, 1'b1);

        // Zero cap, binary and heartbeat share a code.
        write_config(25'd0, 8'd0, 8'd255, 8'd255);
        send_header(32'd0, 8'd255, 1'b0);
        send_header(32'd1, 8'd0, 1'b0);
        send_discard(3);

        // Largest cap, extreme codes.
        write_config('1, 8'd128, 8'd255, 8'd0);
        send_header(32'd33554432, 8'd0, 1'b1);
        send_header(32'd3, 8'd0, 1'b0);
        send_payload(3);

        // Random frames under a new register setting every so often.
        stream_start = bytes_sent;
        next_cfg_at  = bytes_sent;
        done_bytes   = 0;
        while (done_bytes < STREAM_BYTES) begin
            if (bytes_sent >= next_cfg_at) begin
                case ($urandom_range(0, 3))
                    0:       cap = '0;
                    1:       cap = MAX_LEN_W'($urandom_range(1, 64));
                    2:       cap = '1;
                    default: cap = MAX_LEN_W'($urandom);
                endcase
                j = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
                h = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0) b = j;
                if ($urandom_range(0, 3) == 0) h = b;
                write_config(cap, j, b, h);
                next_cfg_at = bytes_sent + CFG_EVERY;
            end
            // One stretch runs with neither side idling.
            in_gaps  = !(done_bytes >= 400 && done_bytes < 600);
            out_gaps = in_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if (cap_now == '0 || pick < 6) begin
                    len = 0;
                end else if (pick < 48) begin
                    len = $urandom_range(1, (cap_now < 12) ? cap_now : 12);
                end else begin
                    len = $urandom_range(1, (cap_now < 40) ? cap_now : 40);
                end
                send_frame(len);
            end else begin
                send_bad_header(pick < 80);
            end
            done_bytes = bytes_sent - stream_start;
        end

        // Drain and settle before the verdict.
        in_valid <= 1'b0;
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        while (due_count != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
